@@ rtl/asdfr_pkg.sv @@
// Shared types and constants for the converter slot router.
package asdfr_pkg;

    localparam int NUM_VITALS   = 4;
    localparam int NUM_SLOTS    = 8;
    localparam int MAX_LANES    = 4;
    localparam int BUFFER_DEPTH = 1023;

    localparam int SLOT_W    = 3;
    localparam int SAMPLE_W  = 24;
    localparam int VITAL_W   = 2;
    localparam int LANE_W    = 2;
    localparam int USED_W    = 3;
    localparam int SKIP_W    = 8;
    localparam int FILL_W    = 10;
    localparam int ENTRY_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 40;

    localparam int SLOT_MAP_W = ENTRY_W * NUM_SLOTS;
    localparam int SKIPS_W    = SKIP_W * NUM_VITALS;
    localparam int BLENS_W    = FILL_W * NUM_VITALS;
    localparam int LPV_W      = USED_W * NUM_VITALS;
    localparam int ADDR_W     = (NUM_VITALS > 1) ? $clog2(NUM_VITALS) : 1;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_SKIPPED  = 3'd1,
        ST_OVERV    = 3'd2,
        ST_UNMAPPED = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_MAP    = 2'd0,
        CFG_SKIP_COUNTS = 2'd1,
        CFG_BUF_LENGTHS = 2'd2,
        CFG_LANES       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [SAMPLE_W-1:0] sample;
        logic                ov_flag;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [VITAL_W-1:0]  vital_id;
        logic [LANE_W-1:0]   lane_id;
        logic [FILL_W-1:0]   write_index;
        logic [SAMPLE_W-1:0] sample_out;
        logic                frame_done;
    } out_item_t;

    typedef struct packed {
        logic [SLOT_MAP_W-1:0] slot_map;
        logic [SKIPS_W-1:0]    skip_counts;
        logic [BLENS_W-1:0]    buffer_lengths;
        logic [LPV_W-1:0]      lanes_per_vital;
    } cfg_t;

    // One memory row per vital: its decimation counter and the fill counts of its lanes.
    typedef struct packed {
        logic [SKIP_W-1:0]                 skip_cnt;
        logic [MAX_LANES-1:0][FILL_W-1:0]  fill;
    } row_t;

    // Decoded reading as it waits for its memory row.
    typedef struct packed {
        status_t             pre_status;
        logic [VITAL_W-1:0]  vital;
        logic [LANE_W-1:0]   lane;
        logic [USED_W-1:0]   used;
        logic [SKIP_W-1:0]   skip;
        logic [FILL_W-1:0]   blen;
        logic [SAMPLE_W-1:0] sample;
    } dec_t;

endpackage

@@ rtl/asdfr_decode.sv @@
// Slot map lookup and per-vital configuration selection for one reading.
module asdfr_decode
    import asdfr_pkg::*;
(
    input  in_item_t item,
    input  cfg_t     cfg,
    output dec_t     dec
);

    logic [ENTRY_W-1:0] entry;
    logic [VITAL_W-1:0] vital;
    logic [LANE_W-1:0]  lane;
    logic [USED_W-1:0]  used_raw;
    logic [USED_W-1:0]  used;
    logic [FILL_W-1:0]  blen_raw;
    logic               slot_ok;
    logic               vital_ok;

    assign slot_ok  = 32'(item.slot) < NUM_SLOTS;
    assign entry    = slot_ok ? cfg.slot_map[ENTRY_W*item.slot +: ENTRY_W] : '0;
    assign vital    = entry[LANE_W +: VITAL_W];
    assign lane     = entry[LANE_W-1:0];
    assign vital_ok = 32'(vital) < NUM_VITALS;

    always_comb begin
        used_raw = vital_ok ? cfg.lanes_per_vital[USED_W*vital +: USED_W] : '0;
        used     = (32'(used_raw) > MAX_LANES) ? USED_W'(MAX_LANES) : used_raw;
        blen_raw = vital_ok ? cfg.buffer_lengths[FILL_W*vital +: FILL_W] : '0;

        dec.vital  = vital;
        dec.lane   = lane;
        dec.used   = used;
        dec.skip   = vital_ok ? cfg.skip_counts[SKIP_W*vital +: SKIP_W] : '0;
        dec.blen   = (32'(blen_raw) > BUFFER_DEPTH) ? FILL_W'(BUFFER_DEPTH) : blen_raw;
        dec.sample = item.sample;

        if (item.ov_flag) begin
            dec.pre_status = ST_OVERV;
        end else if (!slot_ok || !entry[ENTRY_W-1] || !vital_ok
                     || {1'b0, lane} >= used) begin
            dec.pre_status = ST_UNMAPPED;
        end else begin
            dec.pre_status = ST_STORED;
        end
    end

endmodule

@@ rtl/asdfr_state_ram.sv @@
// Per-vital state memory with registered read and row valid bits.
module asdfr_state_ram
    import asdfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output row_t              rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  row_t              wr_data
);

    row_t                  mem [NUM_VITALS];
    row_t                  rd_data_reg;
    logic                  rd_vld_reg;
    logic [NUM_VITALS-1:0] row_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A row never written since reset reads as all zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ rtl/asdfr_update.sv @@
// Decimation, lane fill and frame completion for one reading and its state row.
module asdfr_update
    import asdfr_pkg::*;
(
    input  dec_t      dec,
    input  row_t      cur_row,
    output row_t      new_row,
    output logic      wr_req,
    output out_item_t result
);

    always_comb begin
        logic [FILL_W-1:0] fill;
        logic              all_full;

        new_row  = cur_row;
        result   = '0;
        fill     = cur_row.fill[dec.lane];
        all_full = 1'b1;
        wr_req   = (dec.pre_status == ST_STORED);

        if (!wr_req) begin
            result.status = dec.pre_status;
        end else begin
            result.vital_id = dec.vital;
            result.lane_id  = dec.lane;
            if (cur_row.skip_cnt != dec.skip) begin
                new_row.skip_cnt = cur_row.skip_cnt + 1'b1;
                result.status    = ST_SKIPPED;
            end else begin
                new_row.skip_cnt = '0;
                if (fill < dec.blen) begin
                    result.status           = ST_STORED;
                    result.write_index      = fill;
                    result.sample_out       = dec.sample;
                    new_row.fill[dec.lane]  = fill + 1'b1;
                end else begin
                    result.status = ST_FULL;
                end

                // The frame completes when every used lane holds exactly the length.
                if (new_row.fill[dec.lane] == dec.blen) begin
                    for (int i = 0; i < MAX_LANES; i++) begin
                        if (USED_W'(i) < dec.used && new_row.fill[i] != dec.blen) begin
                            all_full = 1'b0;
                        end
                    end
                    if (all_full) begin
                        for (int i = 0; i < MAX_LANES; i++) begin
                            if (USED_W'(i) < dec.used) begin
                                new_row.fill[i] = '0;
                            end
                        end
                        result.frame_done = 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/adc_slot_decimate_frame_router.sv @@
// Top level of the converter slot router: configuration, pipeline and forwarding.
//
//  Channel   Ports                          Direction  Payload
//  input     s_valid s_ready s_data         in         in_item_t (slot, sample, flag)
//  result    m_valid m_ready m_data         out        out_item_t (one per reading)
//  config    cfg_valid cfg_ready cfg_index  in         cfg_data, 40 bits
//
// One reading is taken every cycle unless the output stalls; each result passes through
// the stage and output registers. A vital's state row is read from memory at the transfer,
// updated and written back as the stage moves on, and forwarded to a following reading.
// Reset clears configuration and marks every state row invalid (it reads as zero).
// The update stage stalls while the output register holds a result that is not taken,
// and the input stalls with it.
module adc_slot_decimate_frame_router
    import asdfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_index_t           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t               cfg_reg;
    dec_t               dec_next;
    dec_t               s1_reg;
    logic               s1_vld_reg;
    out_item_t          out_reg;
    logic               out_vld_reg;
    logic               fwd_vld_reg;
    logic [ADDR_W-1:0]  fwd_vital_reg;
    row_t               fwd_row_reg;
    row_t               ram_rd_data;
    row_t               cur_row;
    row_t               row_next;
    logic               wr_req;
    out_item_t          result_next;
    logic               s_fire;
    logic               s1_fire;
    logic               wr_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SLOT_MAP:    cfg_reg.slot_map        <= cfg_data[SLOT_MAP_W-1:0];
                CFG_SKIP_COUNTS: cfg_reg.skip_counts     <= cfg_data[SKIPS_W-1:0];
                CFG_BUF_LENGTHS: cfg_reg.buffer_lengths  <= cfg_data[BLENS_W-1:0];
                CFG_LANES:       cfg_reg.lanes_per_vital <= cfg_data[LPV_W-1:0];
                default:         cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    asdfr_decode u_decode (
        .item (s_data),
        .cfg  (cfg_reg),
        .dec  (dec_next)
    );

    assign s1_fire = s1_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !s1_vld_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;
    assign wr_en   = s1_fire && wr_req;

    asdfr_state_ram u_state_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (ADDR_W'(dec_next.vital)),
        .rd_data (ram_rd_data),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(s1_reg.vital)),
        .wr_data (row_next)
    );

    // The read issued at a transfer misses a write-back of the same edge; take it here.
    assign cur_row = (fwd_vld_reg && fwd_vital_reg == ADDR_W'(s1_reg.vital))
                     ? fwd_row_reg : ram_rd_data;

    asdfr_update u_update (
        .dec     (s1_reg),
        .cur_row (cur_row),
        .new_row (row_next),
        .wr_req  (wr_req),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                s1_vld_reg  <= 1'b1;
                fwd_vld_reg <= wr_en;
            end else if (s1_fire) begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_reg        <= dec_next;
            fwd_vital_reg <= ADDR_W'(s1_reg.vital);
            fwd_row_reg   <= row_next;
        end
        if (s1_fire) begin
            out_reg <= result_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule
